/* sv/assert_macros.svh */
// Assertion macros shared by the parameter set parser RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define HPSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPSP_ASSERT_IMP(lbl, ante, cons)
`define HPSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/hpsp_pkg.sv */
// Package for the parameter set parser: command/status types, codes, SAR tables.
// No dependencies.
package hpsp_pkg;

    localparam logic [7:0] HDR_SPS  = 8'h67;
    localparam logic [7:0] HDR_PPS  = 8'h68;
    localparam logic [7:0] EMU_BYTE = 8'h03;
    localparam logic [7:0] SAR_EXTENDED = 8'd255;
    localparam int NFIELDS = 17;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_SPS  = 2'd1;
    localparam logic [1:0] K_PPS  = 2'd2;

    localparam logic [4:0] FID_TICK  = 5'd13;
    localparam logic [4:0] FID_FIXED = 5'd15;
    localparam logic [4:0] FID_CABAC = 5'd16;

    typedef struct packed {
        logic       hdr;
        logic [7:0] hdr_byte;
        logic       bit_vld;
        logic       bit_val;
        logic       nal_end;
    } hpsp_cmd_t;

    typedef struct packed {
        logic at_header;
    } hpsp_stat_t;

    function automatic logic [7:0] sar_w(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:  r = 8'd1;
            4'd1:  r = 8'd12;
            4'd2:  r = 8'd10;
            4'd3:  r = 8'd16;
            4'd4:  r = 8'd40;
            4'd5:  r = 8'd24;
            4'd6:  r = 8'd20;
            4'd7:  r = 8'd32;
            4'd8:  r = 8'd80;
            4'd9:  r = 8'd18;
            4'd10: r = 8'd15;
            4'd11: r = 8'd64;
            4'd12: r = 8'd160;
            4'd13: r = 8'd4;
            4'd14: r = 8'd3;
            default: r = 8'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sar_h(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:  r = 8'd1;
            4'd1:  r = 8'd11;
            4'd2:  r = 8'd11;
            4'd3:  r = 8'd11;
            4'd4:  r = 8'd33;
            4'd5:  r = 8'd11;
            4'd6:  r = 8'd11;
            4'd7:  r = 8'd11;
            4'd8:  r = 8'd33;
            4'd9:  r = 8'd11;
            4'd10: r = 8'd11;
            4'd11: r = 8'd33;
            4'd12: r = 8'd99;
            4'd13: r = 8'd3;
            4'd14: r = 8'd2;
            default: r = 8'd1;
        endcase
        return r;
    endfunction

endpackage

/* sv/hpsp_in_if.sv */
// Input channel: one raw NAL byte per transaction.
// No dependencies.
interface hpsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/hpsp_out_if.sv */
// Output channel: one parsed field per transaction.
// No dependencies.
interface hpsp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [32:0] field_value;
    logic        run_end;
    modport source (output valid, output field_id, output field_value, output run_end,
                    input ready);
    modport sink   (input valid, input field_id, input field_value, input run_end,
                    output ready);
endinterface

/* sv/hpsp_syntax.sv */
// Bit-serial SPS/PPS syntax engine with Exp-Golomb reader and field store.
// Depends on hpsp_pkg.
module hpsp_syntax
    import hpsp_pkg::*;
#(
    parameter int MAX_GOLOMB_BITS = 32,
    parameter int MAX_POC_CYCLE   = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  hpsp_cmd_t   cmd,
    input  logic [4:0]  rd_idx,
    output logic [31:0] rd_data,
    output hpsp_stat_t  stat
);

    localparam int ZW = $clog2(MAX_GOLOMB_BITS + 1);

    localparam logic [6:0] ST_HEADER = 7'd0,  ST_DONE = 7'd1,  ST_PROFILE = 7'd2,
        ST_CONSTR = 7'd3,  ST_LEVEL = 7'd4,  ST_SPSID = 7'd5,  ST_CHROMA = 7'd6,
        ST_SEPPLANE = 7'd7, ST_DEPTHL = 7'd8, ST_DEPTHC = 7'd9, ST_BYPASS = 7'd10,
        ST_MATRIXF = 7'd11, ST_LISTF = 7'd12, ST_DELTA = 7'd13, ST_LOG2FN = 7'd14,
        ST_POCTYPE = 7'd15, ST_LOG2POC = 7'd16, ST_DPOZ = 7'd17, ST_OFFNR = 7'd18,
        ST_OFFTB = 7'd19, ST_NCYCLE = 7'd20, ST_OFFREF = 7'd21, ST_REFS = 7'd22,
        ST_GAPS = 7'd23, ST_WMBS = 7'd24, ST_HMAP = 7'd25, ST_FMO = 7'd26,
        ST_MBAFF = 7'd27, ST_D8 = 7'd28, ST_CROPF = 7'd29, ST_CROP = 7'd30,
        ST_VUI = 7'd31, ST_ARF = 7'd32, ST_ARIDC = 7'd33, ST_SARW = 7'd34,
        ST_SARH = 7'd35, ST_OVF = 7'd36, ST_OVAPP = 7'd37, ST_VSTF = 7'd38,
        ST_VFMT = 7'd39, ST_COLF = 7'd40, ST_COLDESC = 7'd41, ST_CLF = 7'd42,
        ST_CLTOP = 7'd43, ST_CLBOT = 7'd44, ST_TIMF = 7'd45, ST_UNITS = 7'd46,
        ST_TSCALE = 7'd47, ST_FIXED = 7'd48, ST_PPSID = 7'd49, ST_PPSSPS = 7'd50,
        ST_ENTROPY = 7'd51;

    logic [6:0]    step_reg;
    logic          ue_reg;
    logic          info_reg;
    logic [5:0]    need_reg;
    logic [5:0]    got_reg;
    logic [ZW-1:0] zcnt_reg;
    logic [31:0]   acc_reg;
    logic [7:0]    loop_reg;
    logic [7:0]    last_scale_reg;
    logic [7:0]    next_scale_reg;
    logic [1:0]    chroma_reg;
    logic          chroma_big_reg;
    logic          sep_reg;
    logic          fmo_reg;
    logic [31:0]   wmbs_reg;
    logic [31:0]   hmap_reg;
    logic [31:0]   crop_reg [4];
    logic [31:0]   units_reg;
    logic [31:0]   tscale_reg;
    logic [3:0]    list_idx_reg;
    logic [3:0]    list_total_reg;
    logic [6:0]    list_size_reg;
    logic [6:0]    list_pos_reg;
    logic [31:0]   fld_reg [NFIELDS];

    logic          bit_act;
    logic [31:0]   acc_sh;
    logic [5:0]    got_inc;
    logic [32:0]   mask;
    logic          done;
    logic [31:0]   val;
    logic          cat_zero, cat_one, cat_three;
    logic          sx;
    logic [1:0]    sy;
    logic [31:0]   crop3;
    logic [31:0]   width_v, height_v;
    logic [31:0]   hbase;
    logic [7:0]    ns;
    logic [6:0]    pos_inc;
    logic [3:0]    idx_inc;
    logic          hi_prof;
    logic [31:0]   prof;
    logic [3:0]    sar_i;

    function automatic logic cat_three_raw(input logic [1:0] c, input logic big);
        return !big && c == 2'd3;
    endfunction

    assign rd_data        = fld_reg[rd_idx];
    assign stat.at_header = (step_reg == ST_HEADER);

    assign bit_act = cmd.bit_vld && (step_reg != ST_DONE) && (step_reg != ST_HEADER);
    assign acc_sh  = {acc_reg[30:0], cmd.bit_val};
    assign got_inc = got_reg + 6'd1;
    assign mask    = (33'd1 << zcnt_reg) - 33'd1;

    always_comb
    begin
        done = 1'b0;
        val  = acc_sh;
        if (bit_act)
        begin
            if (ue_reg)
            begin
                if (!info_reg)
                begin
                    if (cmd.bit_val && (zcnt_reg == '0))
                    begin
                        done = 1'b1;
                        val  = '0;
                    end
                end
                else if (got_inc >= 6'(zcnt_reg))
                begin
                    done = 1'b1;
                    val  = acc_sh + mask[31:0];
                end
            end
            else if (got_inc >= need_reg)
            begin
                done = 1'b1;
            end
        end
    end

    // crop units and cropped size
    assign cat_zero  = sep_reg || (!chroma_big_reg && chroma_reg == 2'd0);
    assign cat_one   = !sep_reg && !chroma_big_reg && chroma_reg == 2'd1;
    assign cat_three = !sep_reg && !chroma_big_reg && chroma_reg == 2'd3;
    assign sx        = !(cat_zero || cat_three);
    assign sy        = (cat_one && !cat_zero ? 2'd1 : 2'd0) + (fmo_reg ? 2'd0 : 2'd1);
    assign crop3     = (step_reg == ST_CROP) ? val : crop_reg[3];
    assign hbase     = (hmap_reg + 32'd1) << 4;
    assign width_v   = ((wmbs_reg + 32'd1) << 4) - ((crop_reg[0] + crop_reg[1]) << sx);
    assign height_v  = (hbase << (fmo_reg ? 1'b0 : 1'b1)) - ((crop_reg[2] + crop3) << sy);

    // scaling list delta
    assign ns      = val[0] ? (last_scale_reg + 8'((val + 32'd1) >> 1))
                            : (last_scale_reg - 8'(val >> 1));
    assign pos_inc = list_pos_reg + 7'd1;
    assign idx_inc = list_idx_reg + 4'd1;

    assign prof    = fld_reg[0];
    assign hi_prof = prof == 32'd100 || prof == 32'd110 || prof == 32'd122 ||
                     prof == 32'd244 || prof == 32'd44 || prof == 32'd83 ||
                     prof == 32'd86 || prof == 32'd118 || prof == 32'd128 ||
                     prof == 32'd138 || prof == 32'd139 || prof == 32'd134 ||
                     prof == 32'd135;
    assign sar_i   = 4'(val[7:0] - 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_HEADER;
            ue_reg         <= 1'b0;
            info_reg       <= 1'b0;
            need_reg       <= '0;
            got_reg        <= '0;
            zcnt_reg       <= '0;
            acc_reg        <= '0;
            loop_reg       <= '0;
            last_scale_reg <= 8'd8;
            next_scale_reg <= 8'd8;
            chroma_reg     <= 2'd1;
            chroma_big_reg <= 1'b0;
            sep_reg        <= 1'b0;
            fmo_reg        <= 1'b0;
            list_idx_reg   <= '0;
            list_total_reg <= '0;
            list_size_reg  <= '0;
            list_pos_reg   <= '0;
        end
        else if (cmd.nal_end)
        begin
            step_reg <= ST_HEADER;
        end
        else if (cmd.hdr)
        begin
            step_reg <= ST_DONE;
            got_reg  <= '0;
            acc_reg  <= '0;
            zcnt_reg <= '0;
            info_reg <= 1'b0;
            if (cmd.hdr_byte == HDR_SPS)
            begin
                chroma_reg     <= 2'd1;
                chroma_big_reg <= 1'b0;
                sep_reg        <= 1'b0;
                fmo_reg        <= 1'b0;
                step_reg       <= ST_PROFILE;
                ue_reg         <= 1'b0;
                need_reg       <= 6'd8;
            end
            else if (cmd.hdr_byte == HDR_PPS)
            begin
                step_reg <= ST_PPSID;
                ue_reg   <= 1'b1;
            end
        end
        else if (bit_act)
        begin
            acc_reg <= acc_sh;
            got_reg <= got_inc;
            if (ue_reg && !info_reg)
            begin
                acc_reg <= acc_reg;
                got_reg <= got_reg;
                if (!cmd.bit_val)
                begin
                    if (zcnt_reg < ZW'(MAX_GOLOMB_BITS))
                    begin
                        zcnt_reg <= zcnt_reg + ZW'(1);
                    end
                end
                else
                begin
                    info_reg <= 1'b1;
                    got_reg  <= '0;
                    acc_reg  <= '0;
                end
            end
            if (done)
            begin
                got_reg  <= '0;
                acc_reg  <= '0;
                zcnt_reg <= '0;
                info_reg <= 1'b0;
                ue_reg   <= 1'b1;
                need_reg <= 6'd1;
                case (step_reg)
                    ST_PROFILE:
                    begin
                        step_reg <= ST_CONSTR;
                        ue_reg   <= 1'b0;
                        need_reg <= 6'd8;
                    end
                    ST_CONSTR:
                    begin
                        step_reg <= ST_LEVEL;
                        ue_reg   <= 1'b0;
                        need_reg <= 6'd8;
                    end
                    ST_LEVEL:   step_reg <= ST_SPSID;
                    ST_SPSID:   step_reg <= hi_prof ? ST_CHROMA : ST_LOG2FN;
                    ST_CHROMA:
                    begin
                        chroma_reg     <= val[1:0];
                        chroma_big_reg <= (val > 32'd3);
                        if (val == 32'd3)
                        begin
                            step_reg <= ST_SEPPLANE;
                            ue_reg   <= 1'b0;
                        end
                        else
                        begin
                            step_reg <= ST_DEPTHL;
                        end
                    end
                    ST_SEPPLANE:
                    begin
                        sep_reg  <= val[0];
                        step_reg <= ST_DEPTHL;
                    end
                    ST_DEPTHL:  step_reg <= ST_DEPTHC;
                    ST_DEPTHC:
                    begin
                        step_reg <= ST_BYPASS;
                        ue_reg   <= 1'b0;
                    end
                    ST_BYPASS:
                    begin
                        step_reg <= ST_MATRIXF;
                        ue_reg   <= 1'b0;
                    end
                    ST_MATRIXF:
                    begin
                        list_idx_reg <= '0;
                        if (val[0])
                        begin
                            list_total_reg <= cat_three_raw(chroma_reg, chroma_big_reg)
                                              ? 4'd12 : 4'd8;
                            step_reg       <= ST_LISTF;
                            ue_reg         <= 1'b0;
                        end
                        else
                        begin
                            list_total_reg <= '0;
                            step_reg       <= ST_LOG2FN;
                        end
                    end
                    ST_LISTF:
                    begin
                        if (val[0])
                        begin
                            list_size_reg  <= (list_idx_reg < 4'd6) ? 7'd16 : 7'd64;
                            list_pos_reg   <= '0;
                            last_scale_reg <= 8'd8;
                            next_scale_reg <= 8'd8;
                            step_reg       <= ST_DELTA;
                        end
                        else
                        begin
                            list_idx_reg <= idx_inc;
                            if (idx_inc < list_total_reg)
                            begin
                                step_reg <= ST_LISTF;
                                ue_reg   <= 1'b0;
                            end
                            else
                            begin
                                step_reg <= ST_LOG2FN;
                            end
                        end
                    end
                    ST_DELTA:
                    begin
                        next_scale_reg <= ns;
                        if (ns != 8'd0)
                        begin
                            last_scale_reg <= ns;
                        end
                        list_pos_reg <= pos_inc;
                        if (pos_inc < list_size_reg && ns != 8'd0)
                        begin
                            step_reg <= ST_DELTA;
                        end
                        else
                        begin
                            list_idx_reg <= idx_inc;
                            if (idx_inc < list_total_reg)
                            begin
                                step_reg <= ST_LISTF;
                                ue_reg   <= 1'b0;
                            end
                            else
                            begin
                                step_reg <= ST_LOG2FN;
                            end
                        end
                    end
                    ST_LOG2FN:  step_reg <= ST_POCTYPE;
                    ST_POCTYPE:
                    begin
                        if (val == 32'd0)
                        begin
                            step_reg <= ST_LOG2POC;
                        end
                        else if (val == 32'd1)
                        begin
                            step_reg <= ST_DPOZ;
                            ue_reg   <= 1'b0;
                        end
                        else
                        begin
                            step_reg <= ST_REFS;
                        end
                    end
                    ST_LOG2POC: step_reg <= ST_REFS;
                    ST_DPOZ:    step_reg <= ST_OFFNR;
                    ST_OFFNR:   step_reg <= ST_OFFTB;
                    ST_OFFTB:   step_reg <= ST_NCYCLE;
                    ST_NCYCLE:
                    begin
                        if (val > 32'(MAX_POC_CYCLE))
                        begin
                            loop_reg <= 8'(MAX_POC_CYCLE);
                            step_reg <= ST_OFFREF;
                        end
                        else
                        begin
                            loop_reg <= val[7:0];
                            step_reg <= (val == 32'd0) ? ST_REFS : ST_OFFREF;
                        end
                    end
                    ST_OFFREF:
                    begin
                        loop_reg <= loop_reg - 8'd1;
                        step_reg <= (loop_reg == 8'd1) ? ST_REFS : ST_OFFREF;
                    end
                    ST_REFS:
                    begin
                        step_reg <= ST_GAPS;
                        ue_reg   <= 1'b0;
                    end
                    ST_GAPS:    step_reg <= ST_WMBS;
                    ST_WMBS:    step_reg <= ST_HMAP;
                    ST_HMAP:
                    begin
                        step_reg <= ST_FMO;
                        ue_reg   <= 1'b0;
                    end
                    ST_FMO:
                    begin
                        fmo_reg  <= val[0];
                        step_reg <= val[0] ? ST_D8 : ST_MBAFF;
                        ue_reg   <= 1'b0;
                    end
                    ST_MBAFF:
                    begin
                        step_reg <= ST_D8;
                        ue_reg   <= 1'b0;
                    end
                    ST_D8:
                    begin
                        step_reg <= ST_CROPF;
                        ue_reg   <= 1'b0;
                    end
                    ST_CROPF:
                    begin
                        if (val[0])
                        begin
                            loop_reg <= '0;
                            step_reg <= ST_CROP;
                        end
                        else
                        begin
                            step_reg <= ST_VUI;
                            ue_reg   <= 1'b0;
                        end
                    end
                    ST_CROP:
                    begin
                        loop_reg <= loop_reg + 8'd1;
                        if (loop_reg < 8'd3)
                        begin
                            step_reg <= ST_CROP;
                        end
                        else
                        begin
                            step_reg <= ST_VUI;
                            ue_reg   <= 1'b0;
                        end
                    end
                    ST_VUI:
                    begin
                        step_reg <= val[0] ? ST_ARF : ST_DONE;
                        ue_reg   <= 1'b0;
                    end
                    ST_ARF:
                    begin
                        ue_reg <= 1'b0;
                        if (val[0])
                        begin
                            step_reg <= ST_ARIDC;
                            need_reg <= 6'd8;
                        end
                        else
                        begin
                            step_reg <= ST_OVF;
                        end
                    end
                    ST_ARIDC:
                    begin
                        ue_reg <= 1'b0;
                        if (val[7:0] == SAR_EXTENDED)
                        begin
                            step_reg <= ST_SARW;
                            need_reg <= 6'd16;
                        end
                        else
                        begin
                            step_reg <= ST_OVF;
                        end
                    end
                    ST_SARW:
                    begin
                        step_reg <= ST_SARH;
                        ue_reg   <= 1'b0;
                        need_reg <= 6'd16;
                    end
                    ST_SARH:
                    begin
                        step_reg <= ST_OVF;
                        ue_reg   <= 1'b0;
                    end
                    ST_OVF:
                    begin
                        step_reg <= val[0] ? ST_OVAPP : ST_VSTF;
                        ue_reg   <= 1'b0;
                    end
                    ST_OVAPP:
                    begin
                        step_reg <= ST_VSTF;
                        ue_reg   <= 1'b0;
                    end
                    ST_VSTF:
                    begin
                        ue_reg <= 1'b0;
                        if (val[0])
                        begin
                            step_reg <= ST_VFMT;
                            need_reg <= 6'd4;
                        end
                        else
                        begin
                            step_reg <= ST_CLF;
                        end
                    end
                    ST_VFMT:
                    begin
                        step_reg <= ST_COLF;
                        ue_reg   <= 1'b0;
                    end
                    ST_COLF:
                    begin
                        ue_reg <= 1'b0;
                        if (val[0])
                        begin
                            step_reg <= ST_COLDESC;
                            need_reg <= 6'd24;
                        end
                        else
                        begin
                            step_reg <= ST_CLF;
                        end
                    end
                    ST_COLDESC:
                    begin
                        step_reg <= ST_CLF;
                        ue_reg   <= 1'b0;
                    end
                    ST_CLF:
                    begin
                        if (val[0])
                        begin
                            step_reg <= ST_CLTOP;
                        end
                        else
                        begin
                            step_reg <= ST_TIMF;
                            ue_reg   <= 1'b0;
                        end
                    end
                    ST_CLTOP:   step_reg <= ST_CLBOT;
                    ST_CLBOT:
                    begin
                        step_reg <= ST_TIMF;
                        ue_reg   <= 1'b0;
                    end
                    ST_TIMF:
                    begin
                        step_reg <= val[0] ? ST_UNITS : ST_DONE;
                        ue_reg   <= 1'b0;
                        need_reg <= 6'd32;
                    end
                    ST_UNITS:
                    begin
                        step_reg <= ST_TSCALE;
                        ue_reg   <= 1'b0;
                        need_reg <= 6'd32;
                    end
                    ST_TSCALE:
                    begin
                        step_reg <= ST_FIXED;
                        ue_reg   <= 1'b0;
                    end
                    ST_PPSID:   step_reg <= ST_PPSSPS;
                    ST_PPSSPS:
                    begin
                        step_reg <= ST_ENTROPY;
                        ue_reg   <= 1'b0;
                    end
                    default:    step_reg <= ST_DONE;
                endcase
            end
        end
    end

    // payload: parsed values and working operands
    always_ff @(posedge clk)
    begin
        if (!cmd.nal_end && cmd.hdr && cmd.hdr_byte == HDR_SPS)
        begin
            wmbs_reg    <= '0;
            hmap_reg    <= '0;
            crop_reg[0] <= '0;
            crop_reg[1] <= '0;
            crop_reg[2] <= '0;
            crop_reg[3] <= '0;
            fld_reg[2]  <= 32'd1;
            fld_reg[3]  <= 32'd8;
            fld_reg[11] <= 32'd1;
            fld_reg[12] <= 32'd1;
        end
        else if (!cmd.nal_end && !cmd.hdr && done)
        begin
            case (step_reg)
                ST_PROFILE: fld_reg[0] <= val;
                ST_LEVEL:   fld_reg[1] <= val;
                ST_CHROMA:
                begin
                    if (val <= 32'd3)
                    begin
                        fld_reg[2] <= val;
                    end
                end
                ST_DEPTHL:  fld_reg[3] <= val + 32'd8;
                ST_LOG2FN:  fld_reg[4] <= val + 32'd4;
                ST_LOG2POC: fld_reg[5] <= val + 32'd4;
                ST_REFS:    fld_reg[6] <= val;
                ST_WMBS:    wmbs_reg <= val;
                ST_HMAP:    hmap_reg <= val;
                ST_FMO:
                begin
                    if (val[0])
                    begin
                        fld_reg[7] <= 32'd1;
                        fld_reg[8] <= 32'd0;
                    end
                end
                ST_MBAFF:   fld_reg[8] <= val;
                ST_CROPF:
                begin
                    if (!val[0])
                    begin
                        fld_reg[9]  <= width_v;
                        fld_reg[10] <= height_v;
                    end
                end
                ST_CROP:
                begin
                    crop_reg[loop_reg[1:0]] <= val;
                    if (loop_reg >= 8'd3)
                    begin
                        fld_reg[9]  <= width_v;
                        fld_reg[10] <= height_v;
                    end
                end
                ST_ARIDC:
                begin
                    if (val[7:0] != SAR_EXTENDED && val != 32'd0 && val < 32'd16)
                    begin
                        fld_reg[11] <= {24'd0, sar_w(sar_i)};
                        fld_reg[12] <= {24'd0, sar_h(sar_i)};
                    end
                end
                ST_SARW:    fld_reg[11] <= val;
                ST_SARH:    fld_reg[12] <= val;
                ST_UNITS:   units_reg <= val;
                ST_TSCALE:  tscale_reg <= val;
                ST_FIXED:
                begin
                    fld_reg[13] <= units_reg;
                    fld_reg[14] <= tscale_reg;
                    fld_reg[15] <= val;
                end
                ST_ENTROPY: fld_reg[16] <= val;
                default:    fld_reg[16] <= fld_reg[16];
            endcase
        end
    end

endmodule

/* sv/h264_parameter_set_parser.sv */
// H.264 SPS/PPS parser. Bytes of one NAL unit arrive one per transaction, header
// byte first, last_byte on the final one. Each payload byte is then shifted,
// MSB first, through the bit-serial syntax engine in state S_BITS, and input
// ready is low meanwhile. Emulation-prevention bytes are dropped without being
// shifted. After the last byte the S_LAST state decides the run; an SPS of 4+
// bytes returns 16 fields, a PPS of 2+ bytes returns the CABAC flag, one field
// per cycle while the sink is ready.
// Depends on hpsp_pkg, hpsp_in_if, hpsp_out_if, hpsp_syntax, assert_macros.svh.
`include "assert_macros.svh"
module h264_parameter_set_parser
    import hpsp_pkg::*;
#(
    parameter int MAX_GOLOMB_BITS = 32,
    parameter int MAX_POC_CYCLE   = 255
)
(
    input  logic clk,
    input  logic rst_n,
    hpsp_in_if.sink    in_bus,
    hpsp_out_if.source out_bus
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BITS = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  zrun_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  bcnt_reg;
    logic [2:0]  bit_cnt_reg;
    logic [7:0]  shift_reg;
    logic        last_reg;
    logic [3:0]  oidx_reg;

    hpsp_cmd_t   cmd;
    hpsp_stat_t  stat;
    logic [4:0]  rd_idx;
    logic [31:0] rd_data;
    logic        in_acc;
    logic        out_acc;
    logic        emit;
    logic        drop;

    assign in_bus.ready = (state_reg == S_IDLE);
    assign in_acc       = in_bus.valid && in_bus.ready;
    assign out_acc      = out_bus.valid && out_bus.ready;
    assign drop         = (in_bus.data_byte == EMU_BYTE) && (zrun_reg == 2'd2);
    assign emit         = (kind_reg == K_SPS && bcnt_reg >= 3'd4) ||
                          (kind_reg == K_PPS && bcnt_reg >= 3'd2);

    assign cmd.hdr      = in_acc && stat.at_header;
    assign cmd.hdr_byte = in_bus.data_byte;
    assign cmd.bit_vld  = (state_reg == S_BITS);
    assign cmd.bit_val  = shift_reg[7];
    assign cmd.nal_end  = (state_reg == S_LAST && !emit) ||
                          (out_acc && out_bus.run_end);

    assign rd_idx              = (kind_reg == K_PPS) ? FID_CABAC : {1'b0, oidx_reg};
    assign out_bus.valid       = (state_reg == S_OUT);
    assign out_bus.field_id    = rd_idx;
    assign out_bus.field_value = (rd_idx == FID_TICK) ? {rd_data, 1'b0} : {1'b0, rd_data};
    assign out_bus.run_end     = (kind_reg == K_PPS) || (rd_idx == FID_FIXED);

    hpsp_syntax #(
        .MAX_GOLOMB_BITS (MAX_GOLOMB_BITS),
        .MAX_POC_CYCLE   (MAX_POC_CYCLE)
    ) u_syntax (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .stat    (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            zrun_reg    <= '0;
            kind_reg    <= K_NONE;
            bcnt_reg    <= '0;
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
            oidx_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        last_reg <= in_bus.last_byte;
                        state_reg <= in_bus.last_byte ? S_LAST : S_IDLE;
                        if (stat.at_header)
                        begin
                            bcnt_reg <= 3'd1;
                            zrun_reg <= '0;
                            kind_reg <= (in_bus.data_byte == HDR_SPS) ? K_SPS :
                                        (in_bus.data_byte == HDR_PPS) ? K_PPS : K_NONE;
                        end
                        else
                        begin
                            if (bcnt_reg < 3'd7)
                            begin
                                bcnt_reg <= bcnt_reg + 3'd1;
                            end
                            if (drop)
                            begin
                                zrun_reg <= '0;
                            end
                            else
                            begin
                                if (in_bus.data_byte == 8'd0)
                                begin
                                    if (zrun_reg < 2'd2)
                                    begin
                                        zrun_reg <= zrun_reg + 2'd1;
                                    end
                                end
                                else
                                begin
                                    zrun_reg <= '0;
                                end
                                bit_cnt_reg <= '0;
                                state_reg   <= S_BITS;
                            end
                        end
                    end
                end
                S_BITS:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_reg <= last_reg ? S_LAST : S_IDLE;
                    end
                end
                S_LAST:
                begin
                    oidx_reg <= '0;
                    if (emit)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        kind_reg  <= K_NONE;
                        bcnt_reg  <= '0;
                        zrun_reg  <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        oidx_reg <= oidx_reg + 4'd1;
                        if (out_bus.run_end)
                        begin
                            state_reg <= S_IDLE;
                            kind_reg  <= K_NONE;
                            bcnt_reg  <= '0;
                            zrun_reg  <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            shift_reg <= in_bus.data_byte;
        end
        else if (state_reg == S_BITS)
        begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
    end

    `HPSP_ASSERT_IMP(a_no_overlap, out_bus.valid, !in_bus.ready)
    `HPSP_ASSERT_NXT(a_run_closes, out_acc && out_bus.run_end, state_reg == S_IDLE)
    `HPSP_ASSERT_NXT(a_bits_eight, state_reg == S_BITS && bit_cnt_reg == 3'd7,
                     state_reg != S_BITS)

endmodule
